>>> hw/rtl/cfpb_pkg.sv
// Package: frame constants, item types and the CRC-8 byte update.
`timescale 1ns / 1ps

package cfpb_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned FRAME_W   = 64;

	localparam logic [BYTE_W-1:0] PREAMBLE_0 = 8'hAA;
	localparam logic [BYTE_W-1:0] PREAMBLE_1 = 8'hA7;
	localparam logic [BYTE_W-1:0] PREAMBLE_2 = 8'h12;
	localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;

	// Byte positions within a frame
	localparam logic [POS_W-1:0] POS_FIRST     = 4'd0;
	localparam logic [POS_W-1:0] POS_CRC_FIRST = 4'd3;
	localparam logic [POS_W-1:0] POS_CRC_LAST  = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST      = 4'd8;

	// One frame request
	typedef struct packed {
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] payload_0;
		logic [BYTE_W-1:0] payload_1;
		logic [BYTE_W-1:0] payload_2;
		logic [BYTE_W-1:0] payload_3;
	} req_t;

	// Hand-over from the request buffer to the serializer
	typedef struct packed {
		logic valid;
		req_t req;
	} req_slot_t;

	// Fold one byte into the CRC, MSB first
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/cfpb_req_buf.sv
// One-entry request buffer that takes the next item while a frame is sent.
`timescale 1ns / 1ps

module cfpb_req_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cfpb_pkg::req_t     in_req,
	input  logic               load,
	output cfpb_pkg::req_slot_t slot
);

	logic           valid_q;
	cfpb_pkg::req_t req_s1;
	logic           accept;

	// Stall only while full and not being drained this cycle
	assign in_stall = valid_q && !load;
	assign accept   = in_valid && !in_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
		end
	end

	assign slot.valid = valid_q;
	assign slot.req   = req_s1;

endmodule

>>> hw/rtl/cfpb_serializer.sv
// Frame serializer: shifts out preamble, id and payload, folds in the CRC.
`timescale 1ns / 1ps

module cfpb_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  cfpb_pkg::req_slot_t slot,
	output logic                load,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          tx_byte,
	output logic                last_byte
);

	logic [cfpb_pkg::FRAME_W-1:0] frame_s2;
	logic [cfpb_pkg::BYTE_W-1:0]  crc_q;
	logic [cfpb_pkg::POS_W-1:0]   pos_q;
	logic                         busy_q;
	logic                         advance;
	logic                         at_last;
	logic                         in_crc_span;
	logic [cfpb_pkg::BYTE_W-1:0]  head_byte;

	assign head_byte   = frame_s2[cfpb_pkg::FRAME_W-1 -: cfpb_pkg::BYTE_W];
	assign at_last     = (pos_q == cfpb_pkg::POS_LAST);
	assign in_crc_span = (pos_q >= cfpb_pkg::POS_CRC_FIRST) &&
		(pos_q <= cfpb_pkg::POS_CRC_LAST);
	assign advance     = busy_q && !out_stall;
	assign load        = slot.valid && (!busy_q || (advance && at_last));

	// Control: busy flag and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= cfpb_pkg::POS_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= cfpb_pkg::POS_FIRST;
		end else if (advance) begin
			if (at_last) begin
				busy_q <= 1'b0;
				pos_q  <= cfpb_pkg::POS_FIRST;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Load a new frame or shift out one byte, updating the CRC
	always_ff @(posedge clk) begin
		if (load) begin
			frame_s2 <= {cfpb_pkg::PREAMBLE_0, cfpb_pkg::PREAMBLE_1,
				cfpb_pkg::PREAMBLE_2, slot.req.frame_id, slot.req.payload_0,
				slot.req.payload_1, slot.req.payload_2, slot.req.payload_3};
			crc_q    <= cfpb_pkg::CRC_INIT;
		end else if (advance) begin
			frame_s2 <= {frame_s2[cfpb_pkg::FRAME_W-cfpb_pkg::BYTE_W-1:0],
				{cfpb_pkg::BYTE_W{1'b0}}};
			if (in_crc_span) begin
				crc_q <= cfpb_pkg::crc8_update(crc_q, head_byte);
			end
		end
	end

	// Drive the output item
	assign out_valid = busy_q;
	assign tx_byte   = at_last ? crc_q : head_byte;
	assign last_byte = at_last;

endmodule

>>> hw/rtl/crc8_framed_packet_builder_core.sv
// Top level of the CRC-8 framed packet builder.
`timescale 1ns / 1ps
// A request is registered in the buffer, then loaded into the serializer's shift
// register. Throughput: one output byte per cycle while out_stall is low, set by
// the shift register; a buffered request loads as the last byte is taken.
// Reset: arst_n clears the buffer occupancy, busy flag and byte position at once;
// no item is shown until a request arrives.

module crc8_framed_packet_builder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_id,
	input  logic [7:0] payload_0,
	input  logic [7:0] payload_1,
	input  logic [7:0] payload_2,
	input  logic [7:0] payload_3,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       last_byte
);

	cfpb_pkg::req_t      in_req;
	cfpb_pkg::req_slot_t slot;
	logic                load;

	// Gather the request fields
	assign in_req.frame_id  = frame_id;
	assign in_req.payload_0 = payload_0;
	assign in_req.payload_1 = payload_1;
	assign in_req.payload_2 = payload_2;
	assign in_req.payload_3 = payload_3;

	cfpb_req_buf u_req_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.load     (load),
		.slot     (slot)
	);

	cfpb_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot      (slot),
		.load      (load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

endmodule

>>> hw/rtl/cfpb_checker.sv
// Port-level checker for the framed packet builder, with its bind.
`timescale 1ns / 1ps

module cfpb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	// Hold a stalled output item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_byte))
		else $error("stalled output item changed");

	// A frame never breaks off before its last byte
	a_frame_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_valid)
		else $error("frame ended before its last byte");

	// A new frame starts with the preamble
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_byte |=> !out_valid || tx_byte == cfpb_pkg::PREAMBLE_0)
		else $error("frame did not start with the preamble");

	// The input side stalls only while a frame is being sent
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while no frame is in flight");

endmodule

bind crc8_framed_packet_builder_core cfpb_checker u_cfpb_checker (.*);

>>> tb/tb.sv
// Testbench for the CRC-8 framed packet builder: random frame requests checked byte by byte.
`timescale 1ns / 1ps

module tb;

	// One expected output byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_beat_t;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	localparam int unsigned FRAME_BYTES = 9;
	localparam int unsigned RANDOM_REQS = 330;

	// Predicts frames and matches them against the serialized bytes
	class frame_scoreboard;
		tx_beat_t    frame_q[$];
		logic [71:0] frame_bits;
		logic [3:0]  byte_pos;
		int unsigned errors;

		function new();
			frame_bits = '0;
			byte_pos   = '0;
			errors     = 0;
		endfunction

		// Bitwise CRC-8, poly 0x07, init 0, over id and payload, MSB first
		function automatic logic [7:0] frame_crc(input logic [39:0] span);
			logic [7:0] crc;
			logic       fb;
			crc = '0;
			for (int b = 39; b >= 0; b--) begin
				fb  = crc[7] ^ span[b];
				crc = {crc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
			end
			return crc;
		endfunction

		// Build the expected frame for an accepted request
		function void note_request(input cfpb_pkg::req_t r);
			logic [39:0] span;
			tx_beat_t    beat;
			span = {r.frame_id, r.payload_0, r.payload_1, r.payload_2, r.payload_3};
			frame_bits = {cfpb_pkg::PREAMBLE_0, cfpb_pkg::PREAMBLE_1, cfpb_pkg::PREAMBLE_2,
				span, frame_crc(span)};
			for (int i = 0; i < FRAME_BYTES; i++) begin
				beat.data = frame_bits[71 - 8 * i -: 8];
				beat.last = (i == FRAME_BYTES - 1);
				frame_q.push_back(beat);
			end
		endfunction

		// Compare one output byte with the oldest expectation
		function void check_byte(input logic [7:0] data, input logic last);
			tx_beat_t exp_beat;
			if (frame_q.size() == 0) begin
				$error("unexpected item: tx_byte %02h last_byte %0b", data, last);
				errors++;
				return;
			end
			exp_beat = frame_q.pop_front();
			if (data !== exp_beat.data) begin
				$error("tx_byte at position %0d: expected %02h, actual %02h",
					byte_pos, exp_beat.data, data);
				errors++;
			end
			if (last !== exp_beat.last) begin
				$error("last_byte at position %0d: expected %0b, actual %0b",
					byte_pos, exp_beat.last, last);
				errors++;
			end
			byte_pos = exp_beat.last ? 4'd0 : byte_pos + 4'd1;
		endfunction

		function int unsigned pending();
			return frame_q.size();
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] frame_id  = 8'h00;
	logic [7:0] payload_0 = 8'h00;
	logic [7:0] payload_1 = 8'h00;
	logic [7:0] payload_2 = 8'h00;
	logic [7:0] payload_3 = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] tx_byte;
	logic       last_byte;

	frame_scoreboard sb = new();

	crc8_framed_packet_builder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.frame_id  (frame_id),
		.payload_0 (payload_0),
		.payload_1 (payload_1),
		.payload_2 (payload_2),
		.payload_3 (payload_3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Note accepted requests and check accepted bytes
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_request({frame_id, payload_0, payload_1, payload_2, payload_3});
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_byte(tx_byte, last_byte);
		end
	end

	// Switch the receiver between stall patterns, picked at random when mode_left runs out
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left  = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(20, 80);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
			default:        out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Present one request and hold it until accepted
	task automatic send_request(input cfpb_pkg::req_t r);
		{frame_id, payload_0, payload_1, payload_2, payload_3} <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, with noise on frame_id, payload_0 and payload_3
	task automatic idle_cycles(input int unsigned n);
		repeat (n) begin
			in_valid  <= 1'b0;
			frame_id  <= 8'($urandom);
			payload_0 <= 8'($urandom);
			payload_3 <= 8'($urandom);
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	cfpb_pkg::req_t directed_q[$];
	cfpb_pkg::req_t req;
	cfpb_pkg::req_t prev_req;
	int unsigned    burst_left;

	initial begin
		// Extremes, single hot fields, alternating bits, id wrap and a resubmitted item
		directed_q = '{
			40'h00_00_00_00_00, 40'hFF_FF_FF_FF_FF,
			40'hFF_00_00_00_00, 40'h00_FF_00_00_00, 40'h00_00_FF_00_00,
			40'h00_00_00_FF_00, 40'h00_00_00_00_FF,
			40'h55_AA_55_AA_55, 40'hAA_55_AA_55_AA,
			40'h80_01_80_01_80, 40'h01_80_01_80_01,
			40'hFE_12_34_56_78, 40'hFF_12_34_56_78, 40'h00_12_34_56_78,
			40'h00_12_34_56_78, 40'hAA_A7_12_AA_A7
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			send_request(directed_q[i]);
		end
		prev_req = directed_q[directed_q.size() - 1];
		idle_cycles(3);

		// Bursts of random requests with random gaps between them
		burst_left = 0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
				burst_left = $urandom_range(1, 16);
			end
			if ($urandom_range(0, 9) == 0) begin
				req = prev_req;
			end else begin
				req = {random_byte(), random_byte(), random_byte(), random_byte(),
					random_byte()};
			end
			send_request(req);
			prev_req = req;
			burst_left--;
		end
		idle_cycles(1);

		// Drain, then give the pipeline time to show any stray byte
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#5ms;
		$display("tb failed");
		$finish;
	end

endmodule
